// ----- hdl/lovg_pkg.sv -----
package lovg_pkg;

  // grid geometry
  localparam int X_CELLS    = 64;
  localparam int Y_CELLS    = 64;
  localparam int Z_CELLS    = 16;
  localparam int GRID_CELLS = X_CELLS * Y_CELLS * Z_CELLS;
  localparam int ADDR_W     = $clog2(GRID_CELLS);

  localparam int COORD_W = 10;
  localparam int VAL_W   = 12;
  localparam int RAD_W   = 8;
  localparam int WIN_W   = COORD_W + 2;
  localparam int CELL_W  = VAL_W + 1;   // {known, log odds}
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  // register reset values
  localparam logic signed [VAL_W-1:0] CLAMP_MIN_RST = -12'sd510;
  localparam logic signed [VAL_W-1:0] CLAMP_MAX_RST = 12'sd890;
  localparam logic signed [VAL_W-1:0] OCC_THR_RST   = 12'sd355;
  localparam logic [RAD_W-1:0]        RADIUS_RST    = 8'd10;

  typedef enum logic [2:0] {
    REG_CLAMP_MIN = 3'd0,
    REG_CLAMP_MAX = 3'd1,
    REG_OCC_THR   = 3'd2,
    REG_RAD_X     = 3'd3,
    REG_RAD_Y     = 3'd4,
    REG_RAD_Z     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_MARK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OUTSIDE = 2'd0,
    ST_FREE    = 2'd1,
    ST_OCC     = 2'd2
  } state_code_t;

  typedef enum logic {
    PH_CLEAR = 1'b0,
    PH_RUN   = 1'b1
  } phase_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] clamp_min;
    logic signed [VAL_W-1:0] clamp_max;
    logic signed [VAL_W-1:0] occ_thr;
    logic [RAD_W-1:0]        rad_x;
    logic [RAD_W-1:0]        rad_y;
    logic [RAD_W-1:0]        rad_z;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } wr_t;

endpackage

// ----- hdl/lovg_ram.sv -----
module lovg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lovg_core.sv -----
module lovg_core import lovg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [1:0]                in_action,
  input  logic signed [COORD_W-1:0] in_cell_x,
  input  logic signed [COORD_W-1:0] in_cell_y,
  input  logic signed [COORD_W-1:0] in_cell_z,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_center_z,
  input  logic signed [VAL_W-1:0]   in_log_odds_delta,
  input  cfg_t                      cfg,
  input  logic [CELL_W-1:0]         ram_q,
  output logic [ADDR_W-1:0]         ram_raddr,
  output wr_t                       wr,
  output logic                      out_valid,
  output logic                      out_inside_map,
  output logic [1:0]                out_state_code,
  output logic signed [VAL_W-1:0]   out_cell_value
);

  function automatic logic in_win(input logic signed [COORD_W-1:0] c,
                                  input logic signed [COORD_W-1:0] ctr,
                                  input logic [RAD_W-1:0] r);
    logic signed [WIN_W-1:0] ce;
    logic signed [WIN_W-1:0] lo;
    logic signed [WIN_W-1:0] hi;
    ce = WIN_W'(ctr);
    lo = ce - $signed({{(WIN_W-RAD_W){1'b0}}, r});
    hi = ce + $signed({{(WIN_W-RAD_W){1'b0}}, r});
    return (WIN_W'(c) >= lo) && (WIN_W'(c) <= hi);
  endfunction

  // ---- accept stage: address, bounds, window, forwarding check
  logic              x_ok, y_ok, z_ok, inside0, win0, fwd0;
  logic [ADDR_W-1:0] addr0;

  assign x_ok = !in_cell_x[COORD_W-1] &&
                ({1'b0, in_cell_x[COORD_W-2:0]} < COORD_W'(X_CELLS));
  assign y_ok = !in_cell_y[COORD_W-1] &&
                ({1'b0, in_cell_y[COORD_W-2:0]} < COORD_W'(Y_CELLS));
  assign z_ok = !in_cell_z[COORD_W-1] &&
                ({1'b0, in_cell_z[COORD_W-2:0]} < COORD_W'(Z_CELLS));
  assign inside0 = x_ok && y_ok && z_ok;

  assign addr0 = ADDR_W'(in_cell_x[COORD_W-2:0]) * ADDR_W'(Y_CELLS * Z_CELLS)
               + ADDR_W'(in_cell_y[COORD_W-2:0]) * ADDR_W'(Z_CELLS)
               + ADDR_W'(in_cell_z[COORD_W-2:0]);
  assign ram_raddr = addr0;

  assign win0 = in_win(in_cell_x, in_center_x, cfg.rad_x) &&
                in_win(in_cell_y, in_center_y, cfg.rad_y) &&
                in_win(in_cell_z, in_center_z, cfg.rad_z);

  // ---- update stage registers
  logic                    s1_valid_r;
  logic                    s1_inside_r;
  logic                    s1_win_r;
  logic [1:0]              s1_action_r;
  logic signed [VAL_W-1:0] s1_delta_r;
  logic [ADDR_W-1:0]       s1_addr_r;
  logic                    fwd_hit_r;
  logic [CELL_W-1:0]       fwd_data_r;
  logic [CELL_W-1:0]       cell_after;

  // cell still being updated is the one just issued for read
  assign fwd0 = s1_valid_r && s1_inside_r && inside0 && (addr0 == s1_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_inside_r <= inside0;
      s1_win_r    <= win0;
      s1_action_r <= in_action;
      s1_delta_r  <= in_log_odds_delta;
      s1_addr_r   <= addr0;
      fwd_hit_r   <= fwd0;
      fwd_data_r  <= cell_after;
    end
  end

  // ---- read-modify-write
  logic [CELL_W-1:0]       rd;
  logic                    known;
  logic signed [VAL_W-1:0] unk_val, v, wdata, v_after;
  logic signed [VAL_W:0]   sum;
  logic                    we;
  logic [1:0]              code;

  assign rd      = fwd_hit_r ? fwd_data_r : ram_q;
  assign known   = rd[CELL_W-1];
  // unknown cell reads one LSB below the lower clamp, saturated
  assign unk_val = (cfg.clamp_min == {1'b1, {(VAL_W-1){1'b0}}}) ? cfg.clamp_min
                                                                : cfg.clamp_min - VAL_W'(1);
  assign v       = known ? $signed(rd[VAL_W-1:0]) : unk_val;
  assign sum     = (VAL_W+1)'(v) + (VAL_W+1)'(s1_delta_r);

  always_comb begin
    we    = 1'b0;
    wdata = v;
    unique case (s1_action_r)
      ACT_ADD: begin
        priority if (!s1_delta_r[VAL_W-1] && v >= cfg.clamp_max) begin
          we = 1'b0;
        end else if (s1_delta_r <= 0 && v < cfg.clamp_min) begin
          we    = 1'b1;
          wdata = cfg.clamp_min;
        end else begin
          we = 1'b1;
          priority if (sum > (VAL_W+1)'(cfg.clamp_max) &&
                       (VAL_W+1)'(cfg.clamp_max) >= (VAL_W+1)'(cfg.clamp_min)) begin
            wdata = cfg.clamp_max;
          end else if (sum < (VAL_W+1)'(cfg.clamp_min)) begin
            // min above max collapses to max
            wdata = (cfg.clamp_min > cfg.clamp_max) ? cfg.clamp_max : cfg.clamp_min;
          end else if (sum > (VAL_W+1)'(cfg.clamp_max)) begin
            wdata = cfg.clamp_max;
          end else begin
            wdata = sum[VAL_W-1:0];
          end
        end
      end
      ACT_MARK: begin
        we    = 1'b1;
        wdata = cfg.clamp_max;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign v_after    = we ? wdata : v;
  assign cell_after = we ? {1'b1, wdata} : rd;
  assign code       = (s1_win_r && v_after > cfg.occ_thr) ? ST_OCC : ST_FREE;

  always_comb begin
    wr.en   = s1_valid_r && s1_inside_r && we;
    wr.addr = s1_addr_r;
    wr.data = {1'b1, wdata};
  end

  // ---- result register
  logic                    out_valid_r;
  logic                    out_inside_r;
  logic [1:0]              out_code_r;
  logic signed [VAL_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_inside_r <= s1_inside_r;
      out_code_r   <= s1_inside_r ? code : ST_OUTSIDE;
      out_value_r  <= s1_inside_r ? v_after : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_map = out_inside_r;
  assign out_state_code = out_code_r;
  assign out_cell_value = out_value_r;

`ifndef SYNTH
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, 2))
    else $error("result without a transaction two cycles earlier");

  a_write_inside: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (s1_valid_r && s1_inside_r))
    else $error("memory write for an out-of-map cell");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inside_r) |-> (out_code_r == ST_OUTSIDE && out_value_r == '0))
    else $error("out-of-map result not zero");

  a_write_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && cfg.clamp_min <= cfg.clamp_max) |->
      ($signed(wr.data[VAL_W-1:0]) >= cfg.clamp_min &&
       $signed(wr.data[VAL_W-1:0]) <= cfg.clamp_max))
    else $error("written log odds outside clamp range");
`endif

endmodule

// ----- hdl/log_odds_voxel_grid.sv -----
// Channel   Handshake                 Payload
// --------  ------------------------  ------------------------------------------------
// input     start, busy               in_action, in_cell_x/y/z, in_center_x/y/z,
//                                     in_log_odds_delta
// result    out_valid (one cycle)     out_inside_map, out_state_code, out_cell_value
// config    psel, penable, pwrite,    paddr, pwdata, prdata (APB, register i at 4*i)
//           pready
//
// One transaction per cycle unless busy; results pass the update and result registers.
// The cell store is one 13-bit synchronous RAM ({known, log odds}); the
// read-modify-write sits in the update stage, and a back-to-back transaction on the same
// cell takes the updated value through a forwarding register.
// After reset busy stays high while a sweep clears the known bit of all GRID_CELLS (65536)
// cells; configuration writes are taken during the sweep.
// The receiver cannot stall: out_valid marks a result for exactly one cycle.
module log_odds_voxel_grid import lovg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic signed [COORD_W-1:0] in_cell_x,
  input  logic signed [COORD_W-1:0] in_cell_y,
  input  logic signed [COORD_W-1:0] in_cell_z,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_center_z,
  input  logic signed [VAL_W-1:0]   in_log_odds_delta,
  // result channel
  output logic                      out_valid,
  output logic                      out_inside_map,
  output logic [1:0]                out_state_code,
  output logic signed [VAL_W-1:0]   out_cell_value,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  // ---- configuration registers
  cfg_t     cfg_r;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clamp_min <= CLAMP_MIN_RST;
      cfg_r.clamp_max <= CLAMP_MAX_RST;
      cfg_r.occ_thr   <= OCC_THR_RST;
      cfg_r.rad_x     <= RADIUS_RST;
      cfg_r.rad_y     <= RADIUS_RST;
      cfg_r.rad_z     <= RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CLAMP_MIN: cfg_r.clamp_min <= pwdata[VAL_W-1:0];
        REG_CLAMP_MAX: cfg_r.clamp_max <= pwdata[VAL_W-1:0];
        REG_OCC_THR:   cfg_r.occ_thr   <= pwdata[VAL_W-1:0];
        REG_RAD_X:     cfg_r.rad_x     <= pwdata[RAD_W-1:0];
        REG_RAD_Y:     cfg_r.rad_y     <= pwdata[RAD_W-1:0];
        REG_RAD_Z:     cfg_r.rad_z     <= pwdata[RAD_W-1:0];
        default:       ;  // unmapped addresses are ignored
      endcase
    end
  end

  // readback, signed registers sign-extended
  always_comb begin
    unique case (cfg_idx)
      REG_CLAMP_MIN: prdata = APB_DW'(cfg_r.clamp_min);
      REG_CLAMP_MAX: prdata = APB_DW'(cfg_r.clamp_max);
      REG_OCC_THR:   prdata = APB_DW'(cfg_r.occ_thr);
      REG_RAD_X:     prdata = APB_DW'(cfg_r.rad_x);
      REG_RAD_Y:     prdata = APB_DW'(cfg_r.rad_y);
      REG_RAD_Z:     prdata = APB_DW'(cfg_r.rad_z);
      default:       prdata = '0;
    endcase
  end

  // ---- clearing sweep control
  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_CLEAR: if (clr_cnt_r == ADDR_W'(GRID_CELLS - 1)) phase_nxt = PH_RUN;
      PH_RUN:   phase_nxt = PH_RUN;
      default:  phase_nxt = PH_CLEAR;
    endcase
  end

  always_comb begin
    clearing    = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    unique case (phase_r)
      PH_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      PH_RUN:  clearing = 1'b0;
      default: clearing = 1'b1;
    endcase
  end

  assign busy = clearing;

  // ---- datapath and cell store
  logic              accept;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_q;
  wr_t               core_wr, ram_wr;

  assign accept = start && !busy;

  lovg_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_action         (in_action),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_cell_z         (in_cell_z),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_center_z       (in_center_z),
    .in_log_odds_delta (in_log_odds_delta),
    .cfg               (cfg_r),
    .ram_q             (ram_q),
    .ram_raddr         (ram_raddr),
    .wr                (core_wr),
    .out_valid         (out_valid),
    .out_inside_map    (out_inside_map),
    .out_state_code    (out_state_code),
    .out_cell_value    (out_cell_value)
  );

  // sweep owns the write port until it finishes
  always_comb begin
    if (clearing) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_cnt_r;
      ram_wr.data = '0;
    end else begin
      ram_wr = core_wr;
    end
  end

  lovg_ram #(
    .WIDTH (CELL_W),
    .DEPTH (GRID_CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

endmodule

// ----- sim/testbench.sv -----
module testbench import lovg_pkg::*; ();

  // action code 3 is unused by the block; it must behave as a query
  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 200;
  localparam int         NUM_PHASES  = 5;

  // Shadow copy of the grid. take_item() runs each accepted transaction through
  // the same update rules as the block and queues the report it must produce;
  // check_report() compares each strobed result against the oldest queued one.
  class voxel_shadow;
    typedef struct {
      logic             in_map;
      logic [1:0]       code;
      logic [VAL_W-1:0] value;
    } cell_report_t;

    logic [VAL_W-1:0] cell_val [GRID_CELLS];
    bit               cell_known [GRID_CELLS];
    cfg_t             regs;
    cell_report_t     pending_reports[$];
    int               errors;

    function new();
      regs.clamp_min = CLAMP_MIN_RST;
      regs.clamp_max = CLAMP_MAX_RST;
      regs.occ_thr   = OCC_THR_RST;
      regs.rad_x     = RADIUS_RST;
      regs.rad_y     = RADIUS_RST;
      regs.rad_z     = RADIUS_RST;
      errors         = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] word);
      case (idx)
        REG_CLAMP_MIN: regs.clamp_min = word[VAL_W-1:0];
        REG_CLAMP_MAX: regs.clamp_max = word[VAL_W-1:0];
        REG_OCC_THR:   regs.occ_thr   = word[VAL_W-1:0];
        REG_RAD_X:     regs.rad_x     = word[RAD_W-1:0];
        REG_RAD_Y:     regs.rad_y     = word[RAD_W-1:0];
        REG_RAD_Z:     regs.rad_z     = word[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction

    // unknown cells read as one LSB under the lower clamp, saturated
    function int effective(int addr);
      int lo;
      if (cell_known[addr]) return $signed(cell_val[addr]);
      lo = $signed(regs.clamp_min) - 1;
      return (lo < -2048) ? -2048 : lo;
    endfunction

    function bit window_hit(int c, int ctr, int r);
      return c >= ctr - r && c <= ctr + r;
    endfunction

    function void store(int addr, int v);
      cell_val[addr]   = v[VAL_W-1:0];
      cell_known[addr] = 1'b1;
    endfunction

    function void take_item(logic [1:0] act, logic signed [COORD_W-1:0] x, y, z, cx, cy, cz,
                            logic signed [VAL_W-1:0] delta);
      int xi, yi, zi, d, v, s, cmin, cmax, thr, addr;
      bit in_win;
      cell_report_t rep;
      xi   = x;
      yi   = y;
      zi   = z;
      d    = delta;
      cmin = $signed(regs.clamp_min);
      cmax = $signed(regs.clamp_max);
      thr  = $signed(regs.occ_thr);
      if (xi < 0 || xi >= X_CELLS || yi < 0 || yi >= Y_CELLS || zi < 0 || zi >= Z_CELLS) begin
        rep.in_map = 1'b0;
        rep.code   = ST_OUTSIDE;
        rep.value  = '0;
        pending_reports = {pending_reports, rep};
        return;
      end
      addr = xi * Y_CELLS * Z_CELLS + yi * Z_CELLS + zi;
      v    = effective(addr);
      if (act == ACT_ADD) begin
        if (d >= 0 && v >= cmax) begin
          // saturated high, cell untouched
        end else if (d <= 0 && v < cmin) begin
          store(addr, cmin);
        end else begin
          s = v + d;
          if (s < cmin) s = cmin;
          if (s > cmax) s = cmax;
          store(addr, s);
        end
      end else if (act == ACT_MARK) begin
        store(addr, cmax);
      end
      v      = effective(addr);
      in_win = window_hit(xi, cx, regs.rad_x) && window_hit(yi, cy, regs.rad_y) &&
               window_hit(zi, cz, regs.rad_z);
      rep.in_map = 1'b1;
      rep.code   = (in_win && v > thr) ? ST_OCC : ST_FREE;
      rep.value  = v[VAL_W-1:0];
      pending_reports = {pending_reports, rep};
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_report(logic in_map, logic [1:0] code, logic [VAL_W-1:0] value);
      cell_report_t want;
      if (pending_reports.size() == 0) begin
        note_error($sformatf("unexpected result: inside=%0d state=%0d value=%0d",
                             in_map, code, $signed(value)));
        return;
      end
      want = pending_reports.pop_front();
      if (in_map !== want.in_map || code !== want.code || value !== want.value)
        note_error($sformatf(
          "mismatch: expected inside=%0d state=%0d value=%0d, got inside=%0d state=%0d value=%0d",
          want.in_map, want.code, $signed(want.value), in_map, code, $signed(value)));
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic                      start             = 1'b0;
  logic                      busy;
  logic [1:0]                in_action         = '0;
  logic signed [COORD_W-1:0] in_cell_x         = '0;
  logic signed [COORD_W-1:0] in_cell_y         = '0;
  logic signed [COORD_W-1:0] in_cell_z         = '0;
  logic signed [COORD_W-1:0] in_center_x       = '0;
  logic signed [COORD_W-1:0] in_center_y       = '0;
  logic signed [COORD_W-1:0] in_center_z       = '0;
  logic signed [VAL_W-1:0]   in_log_odds_delta = '0;

  // result channel
  logic                      out_valid;
  logic                      out_inside_map;
  logic [1:0]                out_state_code;
  logic signed [VAL_W-1:0]   out_cell_value;

  // configuration port
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [APB_AW-1:0]         paddr   = '0;
  logic [APB_DW-1:0]         pwdata  = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  voxel_shadow shadow;
  int          idle_pct = 22;
  int          cycles   = 0;

  // last cell sent, reused now and then so back-to-back hits on one cell
  // exercise the read-modify-write forwarding path
  bit                  have_prev = 1'b0;
  logic [COORD_W-1:0]  prev_x, prev_y, prev_z;

  log_odds_voxel_grid uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_cell_z         (in_cell_z),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_center_z       (in_center_z),
    .in_log_odds_delta (in_log_odds_delta),
    .out_valid         (out_valid),
    .out_inside_map    (out_inside_map),
    .out_state_code    (out_state_code),
    .out_cell_value    (out_cell_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: the slowest legal run (clearing sweep plus every transaction
  // with its longest gap) is well under a fifth of this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Results cannot be held off: every strobe is a transaction at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      shadow.check_report(out_inside_map, out_state_code, out_cell_value);
  end

  // One transaction: optional random gap, then hold start until an edge with
  // busy low. start is never dropped and raised in the same step.
  task automatic send_voxel_op(logic [1:0] act, logic [COORD_W-1:0] x, y, z, cx, cy, cz,
                               logic [VAL_W-1:0] d);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start             <= 1'b1;
    in_action         <= act;
    in_cell_x         <= x;
    in_cell_y         <= y;
    in_cell_z         <= z;
    in_center_x       <= cx;
    in_center_y       <= cy;
    in_center_z       <= cz;
    in_log_odds_delta <= d;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.take_item(act, x, y, z, cx, cy, cz, d);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(reg_idx_t idx, int value);
    logic [APB_DW-1:0] word;
    word             = $urandom;   // upper bits are don't-care for the block
    word[VAL_W-1:0]  = value[VAL_W-1:0];
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.set_reg(idx, word);
  endtask

  // drain: every result back, then an idle margin over the pipe depth
  task automatic settle();
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_phase(int p);
    int vals[6];
    case (p)
      0: vals = '{-200 - int'($urandom_range(800)), 200 + int'($urandom_range(800)),
                  int'($urandom_range(400)) - 200,
                  $urandom_range(30), $urandom_range(30), $urandom_range(30)};
      1: vals = '{-2048, 2047, -2048, 255, 255, 255};
      // inverted clamps, nothing can reach occupied, zero-size window
      2: vals = '{2047, -2048, 2047, 0, 0, 0};
      3: vals = '{$urandom, $urandom, $urandom,
                  $urandom_range(255), $urandom_range(255), $urandom_range(255)};
      default: vals = '{-64, 64, 0,
                        $urandom_range(12, 3), $urandom_range(12, 3), $urandom_range(12, 3)};
    endcase
    for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), vals[i]);
  endtask

  // one of -1, 0, size-1, size: the map boundary from both sides
  function automatic logic [COORD_W-1:0] edge_coord(int size);
    int c;
    case ($urandom_range(3))
      0: c = -1;
      1: c = 0;
      2: c = size - 1;
      default: c = size;
    endcase
    return c[COORD_W-1:0];
  endfunction

  // window center: on the cell, just around the window edge, or anywhere
  function automatic logic [COORD_W-1:0] pick_center(logic [COORD_W-1:0] c);
    int pick, offs;
    pick = $urandom_range(99);
    offs = int'($urandom_range(24)) - 12;
    if (pick < 30) return c;
    if (pick < 65) return c + offs[COORD_W-1:0];
    return $urandom;
  endfunction

  task automatic random_voxel_op();
    logic [1:0]         act;
    logic [COORD_W-1:0] x, y, z;
    logic [VAL_W-1:0]   d;
    int                 pick, offs;

    pick = $urandom_range(99);
    if (pick < 40)      act = ACT_ADD;
    else if (pick < 65) act = ACT_QUERY;
    else if (pick < 85) act = ACT_MARK;
    else                act = ACT_SPARE;

    // mostly in-map cells, many in a small hot corner so cells get revisited
    pick = $urandom_range(99);
    if (pick < 15 && have_prev) begin
      x = prev_x; y = prev_y; z = prev_z;
    end else if (pick < 50) begin
      x = $urandom_range(3); y = $urandom_range(3); z = $urandom_range(3);
    end else if (pick < 82) begin
      x = $urandom_range(X_CELLS-1); y = $urandom_range(Y_CELLS-1);
      z = $urandom_range(Z_CELLS-1);
    end else if (pick < 90) begin
      x = edge_coord(X_CELLS); y = edge_coord(Y_CELLS); z = edge_coord(Z_CELLS);
    end else begin
      x = $urandom; y = $urandom; z = $urandom;
    end

    pick = $urandom_range(99);
    offs = int'($urandom_range(600)) - 300;
    if (pick < 10)      d = '0;
    else if (pick < 20) d = $urandom_range(1) ? 12'h7FF : 12'h800;
    else if (pick < 65) d = offs[VAL_W-1:0];
    else                d = $urandom;

    prev_x = x; prev_y = y; prev_z = z;
    have_prev = 1'b1;
    send_voxel_op(act, x, y, z, pick_center(x), pick_center(y), pick_center(z), d);
  endtask

  initial begin
    shadow = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values (clamps -510/890, threshold 355,
    // radius 10). First transaction waits out the post-reset clearing sweep.
    send_voxel_op(ACT_QUERY, 1, 2, 3, 1, 2, 3, 0);       // unknown cell reads min-1
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, 0);         // zero delta on unknown -> min
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, 100);
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, -2048);     // clamp low
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, 2047);      // clamp high
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, 5);         // at max, positive: hold
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, 0);         // at max, zero: hold
    send_voxel_op(ACT_ADD, 1, 2, 3, 1, 2, 3, -1);
    send_voxel_op(ACT_QUERY, 1, 2, 3, 12, 2, 3, 0);      // one past window edge
    send_voxel_op(ACT_QUERY, 1, 2, 3, 11, 2, 3, 0);      // on window edge
    send_voxel_op(ACT_MARK, 63, 63, 15, -512, -512, -512, 0);
    send_voxel_op(ACT_QUERY, 63, 63, 15, 63, 63, 15, 0);
    send_voxel_op(ACT_SPARE, 1, 2, 3, 1, 2, 3, 2047);    // unused code acts as query
    send_voxel_op(ACT_QUERY, 64, 0, 0, 0, 0, 0, 0);      // out of map on each axis
    send_voxel_op(ACT_ADD, 0, -1, 0, 0, 0, 0, 100);
    send_voxel_op(ACT_MARK, 0, 0, 16, 0, 0, 0, 0);
    send_voxel_op(ACT_QUERY, -512, 511, 0, 511, -512, 0, 0);
    send_voxel_op(ACT_MARK, 0, 64, 0, 0, 0, 0, 0);
    send_voxel_op(ACT_ADD, 511, 0, -1, 0, 0, 0, -5);
    send_voxel_op(ACT_ADD, 5, 5, 5, 5, 5, 5, 1);         // unknown, positive delta
    send_voxel_op(ACT_ADD, 6, 6, 6, 6, 6, 6, -7);        // unknown, negative delta
    send_voxel_op(ACT_ADD, 5, 5, 5, 5, 5, 5, 865);       // exactly at threshold: free
    send_voxel_op(ACT_ADD, 5, 5, 5, 5, 5, 5, 1);         // one above: occupied
    send_voxel_op(ACT_ADD, 0, 0, 0, 0, 0, 0, -2048);
    send_voxel_op(ACT_ADD, 0, 0, 0, 0, 0, 0, 2047);

    // Random phases, each under its own register setting. Writes happen only
    // with the pipe empty.
    for (int p = 0; p < NUM_PHASES; p++) begin
      start <= 1'b0;
      settle();
      program_phase(p);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long stretch of back-to-back transactions in one phase
        idle_pct = (p == 3 && i >= 20 && i < 180) ? 0 : 22;
        random_voxel_op();
      end
    end

    start <= 1'b0;
    settle();
    if (shadow.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
